// ===== sv/json_string_array_unescape_unit_assert.svh =====
// ----------------------------------------------------------------------------
// JSON string array unescape unit - assertion macros
// Shared assertion forms for the checker. Each use names a label, an
// antecedent and a consequent; clock and reset come from the using scope.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ARRAY_UNESCAPE_UNIT_ASSERT_SVH
`define JSON_STRING_ARRAY_UNESCAPE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSAU_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("jsau: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JSAU_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("jsau: next-cycle check failed");

`endif

// ===== sv/jsau_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string array unescape - package
// Types, character codes and decode helpers shared by the unit's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jsau_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_AWAIT_OPEN  = 4'd0,
        PH_AFTER_OPEN  = 4'd1,
        PH_EXPECT_STR  = 4'd2,
        PH_IN_STRING   = 4'd3,
        PH_ESCAPE      = 4'd4,
        PH_HEX         = 4'd5,
        PH_HELD        = 4'd6,
        PH_HELD_BS     = 4'd7,
        PH_AFTER_VALUE = 4'd8,
        PH_DONE        = 4'd9,
        PH_FAILED      = 4'd10
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_EOS  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Code point limits.
    localparam logic [15:0] SUR_HI_MIN  = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX  = 16'hDBFF;
    localparam logic [15:0] SUR_LO_MIN  = 16'hDC00;
    localparam logic [15:0] SUR_LO_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] CP_ONE_MAX   = 21'h00007F;
    localparam logic [20:0] CP_TWO_MAX   = 21'h0007FF;
    localparam logic [20:0] CP_THREE_MAX = 21'h00FFFF;

    // Number of result entries one transaction can cause.
    localparam int MAX_RES = 6;

    // Up to four results from the tail of one step.
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
        logic [3:0][1:0] kinds;
    } tail_t;

    // All results caused by one input transaction.
    typedef struct packed {
        logic [2:0]              count;
        logic [MAX_RES-1:0][7:0] bytes;
        logic [MAX_RES-1:0][1:0] kinds;
    } grp_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } esc_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Hex digit decode; letters map through their low nibble plus nine.
    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    // Simple escape letters and the byte each stands for.
    function automatic esc_t simple_escape(input logic [7:0] c);
        esc_t e;
        e.ok = 1'b1;
        unique case (c)
            CH_QUOTE:  e.val = 8'h22;
            CH_BSLASH: e.val = 8'h5C;
            CH_SLASH:  e.val = 8'h2F;
            CH_LOW_B:  e.val = 8'h08;
            CH_LOW_F:  e.val = 8'h0C;
            CH_LOW_N:  e.val = 8'h0A;
            CH_LOW_R:  e.val = 8'h0D;
            CH_LOW_T:  e.val = 8'h09;
            default:
            begin
                e.ok  = 1'b0;
                e.val = 8'h00;
            end
        endcase
        return e;
    endfunction

    function automatic tail_t tail_mark(input logic [1:0] k);
        tail_t t;
        t          = '0;
        t.count    = 3'd1;
        t.kinds[0] = k;
        return t;
    endfunction

    function automatic tail_t tail_byte(input logic [7:0] b);
        tail_t t;
        t          = '0;
        t.count    = 3'd1;
        t.bytes[0] = b;
        t.kinds[0] = KIND_BYTE;
        return t;
    endfunction

    // UTF-8 encoding of one code point into one to four bytes.
    function automatic tail_t utf8_encode(input logic [20:0] cp);
        tail_t t;
        t = '0;
        if (cp <= CP_ONE_MAX) begin
            t.count    = 3'd1;
            t.bytes[0] = cp[7:0];
        end else if (cp <= CP_TWO_MAX) begin
            t.count    = 3'd2;
            t.bytes[0] = {3'b110, cp[10:6]};
            t.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= CP_THREE_MAX) begin
            t.count    = 3'd3;
            t.bytes[0] = {4'b1110, cp[15:12]};
            t.bytes[1] = {2'b10, cp[11:6]};
            t.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            t.count    = 3'd4;
            t.bytes[0] = {5'b11110, cp[20:18]};
            t.bytes[1] = {2'b10, cp[17:12]};
            t.bytes[2] = {2'b10, cp[11:6]};
            t.bytes[3] = {2'b10, cp[5:0]};
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== sv/jsau_parser.sv =====
// ----------------------------------------------------------------------------
// JSON string array unescape - parser
// Input register, parse state and the single-pass decode that turns one
// input transaction into its group of results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsau_parser
    import jsau_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    output grp_t            grp,
    output logic            grp_valid,
    input  wire logic       grp_ready
);

    logic       inq_valid_reg;
    logic [7:0] byte_reg;
    logic       eot_reg;

    phase_t      phase_reg, phase_next;
    logic [11:0] hex_reg, hex_next;
    logic [1:0]  digits_reg, digits_next;
    logic [9:0]  held_reg, held_next;
    logic        high_reg, high_next;

    logic        consume;
    logic        rel;
    tail_t       tail;
    hex_t        hd;
    esc_t        esc;
    logic [15:0] code;
    logic [20:0] joined;

    // A transaction leaves the input register once its results have a place.
    assign consume   = inq_valid_reg && ((grp.count == 3'd0) || grp_ready);
    assign grp_valid = inq_valid_reg && (grp.count != 3'd0);
    assign in_ready  = !inq_valid_reg || consume;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            inq_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            inq_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            eot_reg  <= end_of_text;
        end
    end

    // Parse state advances when the transaction is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_AWAIT_OPEN;
            hex_reg    <= '0;
            digits_reg <= '0;
            held_reg   <= '0;
            high_reg   <= 1'b0;
        end
        else if (consume)
        begin
            phase_reg  <= phase_next;
            hex_reg    <= hex_next;
            digits_reg <= digits_next;
            held_reg   <= held_next;
            high_reg   <= high_next;
        end
    end

    assign hd     = hex_digit(byte_reg);
    assign esc    = simple_escape(byte_reg);
    assign code   = {hex_reg, hd.val};
    assign joined = SUPP_BASE + {1'b0, held_reg, code[9:0]};

    // Next state and the results of this step.
    always_comb
    begin
        phase_next  = phase_reg;
        hex_next    = hex_reg;
        digits_next = digits_reg;
        held_next   = held_reg;
        high_next   = high_reg;
        rel         = 1'b0;
        tail        = '0;

        if (eot_reg)
        begin
            // End of document: report if unfinished and return to reset.
            if (phase_reg != PH_DONE && phase_reg != PH_FAILED)
            begin
                tail = tail_mark(KIND_BAD);
            end
            phase_next  = PH_AWAIT_OPEN;
            hex_next    = '0;
            digits_next = '0;
            held_next   = '0;
            high_next   = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_AWAIT_OPEN:
                begin
                    if (!is_space(byte_reg))
                    begin
                        if (byte_reg == CH_LBRACK)
                        begin
                            phase_next = PH_AFTER_OPEN;
                        end
                        else
                        begin
                            tail       = tail_mark(KIND_BAD);
                            phase_next = PH_FAILED;
                        end
                    end
                end
                PH_AFTER_OPEN, PH_EXPECT_STR:
                begin
                    if (!is_space(byte_reg))
                    begin
                        if (byte_reg == CH_QUOTE)
                        begin
                            phase_next = PH_IN_STRING;
                        end
                        else if (byte_reg == CH_RBRACK && phase_reg == PH_AFTER_OPEN)
                        begin
                            tail       = tail_mark(KIND_DONE);
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            tail       = tail_mark(KIND_BAD);
                            phase_next = PH_FAILED;
                        end
                    end
                end
                PH_IN_STRING, PH_HELD:
                begin
                    if (byte_reg == CH_BSLASH)
                    begin
                        phase_next = (phase_reg == PH_HELD) ? PH_HELD_BS : PH_ESCAPE;
                    end
                    else
                    begin
                        // A held high surrogate goes out alone before this byte.
                        if (phase_reg == PH_HELD)
                        begin
                            rel       = high_reg;
                            high_next = 1'b0;
                            held_next = '0;
                        end
                        if (byte_reg == CH_QUOTE)
                        begin
                            tail       = tail_mark(KIND_EOS);
                            phase_next = PH_AFTER_VALUE;
                        end
                        else
                        begin
                            tail       = tail_byte(byte_reg);
                            phase_next = PH_IN_STRING;
                        end
                    end
                end
                PH_ESCAPE, PH_HELD_BS:
                begin
                    if (byte_reg == CH_LOW_U)
                    begin
                        hex_next    = '0;
                        digits_next = '0;
                        phase_next  = PH_HEX;
                    end
                    else if (esc.ok)
                    begin
                        if (phase_reg == PH_HELD_BS)
                        begin
                            rel       = high_reg;
                            high_next = 1'b0;
                            held_next = '0;
                        end
                        tail       = tail_byte(esc.val);
                        phase_next = PH_IN_STRING;
                    end
                    else
                    begin
                        tail       = tail_mark(KIND_BAD);
                        phase_next = PH_FAILED;
                    end
                end
                PH_HEX:
                begin
                    if (!hd.ok)
                    begin
                        tail       = tail_mark(KIND_BAD);
                        phase_next = PH_FAILED;
                    end
                    else if (digits_reg == 2'd3)
                    begin
                        digits_next = '0;
                        hex_next    = '0;
                        if (high_reg && code >= SUR_LO_MIN && code <= SUR_LO_MAX)
                        begin
                            // Surrogate pair joined into one supplementary character.
                            tail       = utf8_encode(joined);
                            high_next  = 1'b0;
                            held_next  = '0;
                            phase_next = PH_IN_STRING;
                        end
                        else
                        begin
                            rel       = high_reg;
                            high_next = 1'b0;
                            held_next = '0;
                            if (code >= SUR_HI_MIN && code <= SUR_HI_MAX)
                            begin
                                held_next  = code[9:0];
                                high_next  = 1'b1;
                                phase_next = PH_HELD;
                            end
                            else
                            begin
                                tail       = utf8_encode({5'd0, code});
                                phase_next = PH_IN_STRING;
                            end
                        end
                    end
                    else
                    begin
                        hex_next    = {hex_reg[7:0], hd.val};
                        digits_next = digits_reg + 2'd1;
                    end
                end
                PH_AFTER_VALUE:
                begin
                    if (!is_space(byte_reg))
                    begin
                        if (byte_reg == CH_COMMA)
                        begin
                            phase_next = PH_EXPECT_STR;
                        end
                        else if (byte_reg == CH_RBRACK)
                        begin
                            tail       = tail_mark(KIND_DONE);
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            tail       = tail_mark(KIND_BAD);
                            phase_next = PH_FAILED;
                        end
                    end
                end
                PH_DONE, PH_FAILED:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    phase_next = PH_FAILED;
                end
            endcase
        end
    end

    // Assemble the group: released surrogate bytes first, then the tail.
    always_comb
    begin
        grp = '0;
        if (rel)
        begin
            grp.count    = 3'd3 + tail.count;
            grp.bytes[0] = 8'hED;
            grp.bytes[1] = {4'hA, held_reg[9:6]};
            grp.bytes[2] = {2'b10, held_reg[5:0]};
            grp.kinds[0] = KIND_BYTE;
            grp.kinds[1] = KIND_BYTE;
            grp.kinds[2] = KIND_BYTE;
            for (int i = 0; i < 3; i++)
            begin
                grp.bytes[i+3] = tail.bytes[i];
                grp.kinds[i+3] = tail.kinds[i];
            end
        end
        else
        begin
            grp.count = tail.count;
            for (int i = 0; i < 4; i++)
            begin
                grp.bytes[i] = tail.bytes[i];
                grp.kinds[i] = tail.kinds[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/jsau_out_seq.sv =====
// ----------------------------------------------------------------------------
// JSON string array unescape - output sequencer
// Holds one group of results and hands them out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module jsau_out_seq
    import jsau_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire grp_t       grp,
    input  wire logic       grp_valid,
    output logic            grp_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      out_kind,
    output logic            last_of_run
);

    grp_t       grp_reg;
    logic [2:0] idx_reg;
    logic       full_reg;
    logic       take;

    assign out_valid   = full_reg;
    assign last_of_run = (idx_reg == grp_reg.count - 3'd1);
    assign out_kind    = grp_reg.kinds[idx_reg];
    assign out_byte    = (grp_reg.kinds[idx_reg] == KIND_BYTE) ? grp_reg.bytes[idx_reg] : 8'h00;
    assign take        = full_reg && out_ready;

    // Room for a new group once the final entry of the current one goes.
    assign grp_ready = !full_reg || (take && last_of_run);

    // Occupancy and position within the group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (grp_valid && grp_ready)
        begin
            full_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            if (last_of_run)
            begin
                full_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // Group payload.
    always_ff @(posedge clk)
    begin
        if (grp_valid && grp_ready)
        begin
            grp_reg <= grp;
        end
    end

endmodule

`default_nettype wire

// ===== sv/json_string_array_unescape_unit.sv =====
// Path: a transaction held in the input register is decoded, and its results move on to
// the group register when it has room; the two registers form a two-stage path.
// Throughput: one input transaction per cycle while out_ready is high and each causes at
// most one result; a longer run (up to six) holds the sequencer until its last is taken.
// Reset: rst_n clears the parse state, the input register and the output group at once.
// ----------------------------------------------------------------------------
// JSON string array unescape unit - top level
// Checks a JSON array of strings byte by byte and gives the decoded bytes and marks.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_array_unescape_unit
    import jsau_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      out_kind,
    output logic            last_of_run
);

    grp_t grp;
    logic grp_valid;
    logic grp_ready;

    // Parser stage.
    jsau_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .grp         (grp),
        .grp_valid   (grp_valid),
        .grp_ready   (grp_ready)
    );

    // Output sequencer.
    jsau_out_seq u_out_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp         (grp),
        .grp_valid   (grp_valid),
        .grp_ready   (grp_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .out_kind    (out_kind),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== sv/jsau_checker.sv =====
// ----------------------------------------------------------------------------
// JSON string array unescape - port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_array_unescape_unit_assert.svh"

module jsau_checker
    import jsau_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] out_kind,
    input wire logic       last_of_run
);

    // A stalled result holds its payload.
    `JSAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_kind) && $stable(last_of_run))

    // Marks carry a zero byte.
    `JSAU_ASSERT_NOW(a_mark_zero, out_valid && out_kind != KIND_BYTE, out_byte == 8'h00)

    // Every mark closes its run of results.
    `JSAU_ASSERT_NOW(a_mark_last, out_valid && out_kind != KIND_BYTE, last_of_run)

    // The rest of a run is buffered, so it follows without a gap.
    `JSAU_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !last_of_run, out_valid)

endmodule

bind json_string_array_unescape_unit jsau_checker u_jsau_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .last_of_run (last_of_run)
);

`default_nettype wire
